FILE: src/ldrs_pkg.sv
// ----------------------------------------------------------------------------
// LOOK disk request scheduler package
// Command and status codes shared by the scheduler's files.
// ----------------------------------------------------------------------------
package ldrs_pkg;

   // Command carried by an input transaction.
   localparam logic CMD_ADD      = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   // Status carried by a result transaction.
   typedef enum logic [1:0] {
      STATUS_ADDED      = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_DISPATCHED = 2'd2,
      STATUS_EMPTY      = 2'd3
   } status_type;

endpackage

FILE: src/look_disk_request_scheduler_top.sv
// An add moves up one place every entry above the new sector, at most QUEUE_DEPTH - 1 of them.
// A dispatch scans and compares entries, serves one, then moves the entries behind it down one
// place. Refusals and empty dispatches go straight to the response.
// One transaction at a time, paced by the queue memory.
// Synchronous reset empties the queue, puts the head at sector zero and sets the sweep downward.
// ----------------------------------------------------------------------------
// LOOK disk request scheduler
// Keeps pending requests sorted by start sector in a single memory and serves
// them in elevator order, one read-modify-write step per cycle.
// ----------------------------------------------------------------------------
module look_disk_request_scheduler_top
   import ldrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32,
   parameter int SECTOR_BITS = 48,
   parameter int LENGTH_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic [SECTOR_BITS-1:0]               req_sector,
   input  logic [LENGTH_BITS-1:0]               req_length,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [SECTOR_BITS-1:0]               rsp_out_sector,
   output logic [LENGTH_BITS-1:0]               rsp_out_length,
   output logic                                 rsp_sweep_up,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_pending
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = SECTOR_BITS + LENGTH_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_CMP,
      ST_ADD_PUT,
      ST_SCAN_UP,
      ST_SCAN_DN,
      ST_DSP_ONE,
      ST_SHIFT,
      ST_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [SECTOR_BITS-1:0]   head_ff, head_in;
   logic                     dir_up_ff, dir_up_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [SECTOR_BITS-1:0]   new_sec_ff, new_sec_in;
   logic [LENGTH_BITS-1:0]   new_len_ff, new_len_in;
   status_type               res_status_ff, res_status_in;
   logic [SECTOR_BITS-1:0]   res_sector_ff, res_sector_in;
   logic [LENGTH_BITS-1:0]   res_length_ff, res_length_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [SECTOR_BITS-1:0]   rsp_sector_ff, rsp_sector_in;
   logic [LENGTH_BITS-1:0]   rsp_length_ff, rsp_length_in;
   logic                     rsp_dir_ff, rsp_dir_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   // Queue memory: one write and one registered read per cycle.
   logic [ENTRY_W-1:0]       queue_mem_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0]       rd_data_ff;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ENTRY_W-1:0]       wr_data;

   logic [SECTOR_BITS-1:0]   rd_sec;
   logic [LENGTH_BITS-1:0]   rd_len;
   logic [IDX_W-1:0]         last_idx;
   logic                     take;

   assign rd_sec   = rd_data_ff[ENTRY_W-1:LENGTH_BITS];
   assign rd_len   = rd_data_ff[LENGTH_BITS-1:0];
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_sector = rsp_sector_ff;
   assign rsp_out_length = rsp_length_ff;
   assign rsp_sweep_up   = rsp_dir_ff;
   assign rsp_pending    = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      dir_up_in     = dir_up_ff;
      idx_in        = idx_ff;
      new_sec_in    = new_sec_ff;
      new_len_in    = new_len_ff;
      res_status_in = res_status_ff;
      res_sector_in = res_sector_ff;
      res_length_in = res_length_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_sector_in = rsp_sector_ff;
      rsp_length_in = rsp_length_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_count_in  = rsp_count_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      take          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               new_sec_in    = req_sector;
               new_len_in    = req_length;
               res_sector_in = '0;
               res_length_in = '0;
               if (req_cmd == CMD_ADD) begin
                  res_status_in = STATUS_ADDED;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_RESP;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = {req_sector, req_length};
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_RESP;
                  end else begin
                     // Walk down from the top entry, moving larger sectors up.
                     rd_addr  = last_idx;
                     idx_in   = IDX_W'(count_ff);
                     state_in = ST_ADD_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_RESP;
                  end else if (count_ff == CNT_W'(1)) begin
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_DSP_ONE;
                  end else if (dir_up_ff) begin
                     rd_addr  = '0;
                     idx_in   = '0;
                     state_in = ST_SCAN_UP;
                  end else begin
                     rd_addr  = last_idx;
                     idx_in   = last_idx;
                     state_in = ST_SCAN_DN;
                  end
               end
            end
         end

         ST_ADD_CMP: begin
            // The read data is the entry just below slot idx_ff.
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            if (rd_sec > new_sec_ff) begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - 1'b1;
               if (idx_ff == IDX_W'(1)) begin
                  state_in = ST_ADD_PUT;
               end else begin
                  rd_addr = idx_ff - 1'b1 - 1'b1;
               end
            end else begin
               wr_data  = {new_sec_ff, new_len_ff};
               count_in = count_ff + CNT_W'(1);
               state_in = ST_RESP;
            end
         end

         ST_ADD_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = {new_sec_ff, new_len_ff};
            count_in = count_ff + CNT_W'(1);
            state_in = ST_RESP;
         end

         ST_SCAN_UP: begin
            if (rd_sec > head_ff) begin
               take = 1'b1;
            end else if (idx_ff == last_idx) begin
               // Nothing ahead: reverse and serve the highest entry.
               take      = 1'b1;
               dir_up_in = 1'b0;
            end else begin
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end

         ST_SCAN_DN: begin
            if (rd_sec < head_ff) begin
               take = 1'b1;
            end else if (idx_ff == '0) begin
               // Nothing ahead: reverse and serve the lowest entry.
               take      = 1'b1;
               dir_up_in = 1'b1;
            end else begin
               rd_addr = idx_ff - 1'b1;
               idx_in  = idx_ff - 1'b1;
            end
         end

         ST_DSP_ONE: begin
            take = 1'b1;
         end

         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            if ((CNT_W'(idx_ff) + CNT_W'(2)) < count_ff) begin
               rd_addr = IDX_W'(CNT_W'(idx_ff) + CNT_W'(2));
               idx_in  = idx_ff + 1'b1;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sector_in = res_sector_ff;
               rsp_length_in = res_length_ff;
               rsp_dir_in    = dir_up_ff;
               rsp_count_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Serve the entry in the read register, then close the gap behind it.
      if (take) begin
         res_status_in = STATUS_DISPATCHED;
         res_sector_in = rd_sec;
         res_length_in = rd_len;
         head_in       = rd_sec + SECTOR_BITS'(rd_len);
         if ((CNT_W'(idx_ff) + CNT_W'(1)) < count_ff) begin
            rd_addr  = IDX_W'(CNT_W'(idx_ff) + CNT_W'(1));
            state_in = ST_SHIFT;
         end else begin
            count_in = count_ff - CNT_W'(1);
            state_in = ST_RESP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         dir_up_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         dir_up_ff    <= dir_up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      new_sec_ff    <= new_sec_in;
      new_len_ff    <= new_len_in;
      res_status_ff <= res_status_in;
      res_sector_ff <= res_sector_in;
      res_length_ff <= res_length_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sector_ff <= rsp_sector_in;
      rsp_length_ff <= rsp_length_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= queue_mem_ff[rd_addr];
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("pending count exceeds the queue depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= count_ff))
      else $error("queue write beyond the occupied region");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result transaction raised outside the response state");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> (count_ff == $past(count_ff)) ||
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pending count changed by more than one");
`endif

endmodule

FILE: sim/look_disk_request_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LOOK disk request scheduler testbench
// Drives add and dispatch transactions with random bursts and gaps, stalls the
// result channel on its own pattern, and checks every result against an
// elevator model kept inside a small scoreboard.
// ----------------------------------------------------------------------------
module look_disk_request_scheduler_top_tb;
   import ldrs_pkg::*;

   localparam int QDEPTH      = 32;
   localparam int SEC_W       = 48;
   localparam int LEN_W       = 16;
   localparam int CNT_W       = $clog2(QDEPTH + 1);
   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 2 * QDEPTH + 16;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [SEC_W-1:0] SEC_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef struct packed {
      status_type          status;
      logic [SEC_W-1:0]    sector;
      logic [LEN_W-1:0]    length;
      logic                sweep_up;
      logic [CNT_W-1:0]    pending;
   } sched_result_type;

   class elevator_scoreboard;
      logic [SEC_W-1:0] sectors_q [QDEPTH];
      logic [LEN_W-1:0] lengths_q [QDEPTH];
      int unsigned      count;
      logic [SEC_W-1:0] head;
      logic             moving_up;
      sched_result_type awaited [$];
      int               errors;
      int               checked;
      int               n_full, n_empty, n_reversals, n_wraps, n_served, peak_depth;

      function new();
         count = 0;
         head = '0;
         moving_up = 1'b0;
         errors = 0;
         checked = 0;
         n_full = 0;
         n_empty = 0;
         n_reversals = 0;
         n_wraps = 0;
         n_served = 0;
         peak_depth = 0;
      endfunction

      function void flag_error(string what);
         errors++;
         if (errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
      endfunction

      // Works out the result of one accepted transaction and queues it.
      function void note_request(logic cmd, logic [SEC_W-1:0] sector,
                                 logic [LEN_W-1:0] length);
         sched_result_type res;
         int unsigned      idx, pick;
         logic [SEC_W:0]   sum;
         res = '0;
         if (cmd == CMD_ADD) begin
            if (count >= QDEPTH) begin
               res.status = STATUS_FULL;
               n_full++;
            end else begin
               // New entry goes after every entry with an equal or lower sector.
               idx = count;
               while (idx > 0 && sectors_q[idx-1] > sector) begin
                  sectors_q[idx] = sectors_q[idx-1];
                  lengths_q[idx] = lengths_q[idx-1];
                  idx--;
               end
               sectors_q[idx] = sector;
               lengths_q[idx] = length;
               count++;
               if (count > peak_depth) peak_depth = count;
               res.status = STATUS_ADDED;
            end
         end else if (count == 0) begin
            res.status = STATUS_EMPTY;
            n_empty++;
         end else begin
            pick = count;
            if (count == 1) begin
               pick = 0;
            end else if (moving_up) begin
               for (int i = 0; i < count; i++) begin
                  if (pick == count && sectors_q[i] > head) pick = i;
               end
               if (pick == count) begin
                  moving_up = 1'b0;
                  pick = count - 1;
                  n_reversals++;
               end
            end else begin
               for (int i = count - 1; i >= 0; i--) begin
                  if (pick == count && sectors_q[i] < head) pick = i;
               end
               if (pick == count) begin
                  moving_up = 1'b1;
                  pick = 0;
                  n_reversals++;
               end
            end
            res.status = STATUS_DISPATCHED;
            res.sector = sectors_q[pick];
            res.length = lengths_q[pick];
            for (int i = pick; i + 1 < count; i++) begin
               sectors_q[i] = sectors_q[i+1];
               lengths_q[i] = lengths_q[i+1];
            end
            count--;
            sum = {1'b0, res.sector} + {{(SEC_W + 1 - LEN_W){1'b0}}, res.length};
            if (sum[SEC_W]) n_wraps++;
            head = sum[SEC_W-1:0];
            n_served++;
         end
         res.sweep_up = moving_up;
         res.pending = CNT_W'(count);
         awaited.push_back(res);
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type exp;
         checked++;
         if (awaited.size() == 0) begin
            flag_error($sformatf("unexpected result status=%0d sector=%h length=%h",
                                 got.status, got.sector, got.length));
            return;
         end
         exp = awaited.pop_front();
         if (got.status !== exp.status || got.sector !== exp.sector ||
             got.length !== exp.length || got.sweep_up !== exp.sweep_up ||
             got.pending !== exp.pending) begin
            flag_error($sformatf({"result %0d: expected st=%0d sec=%h len=%h up=%0d pend=%0d,",
                                  " got st=%0d sec=%h len=%h up=%0d pend=%0d"},
                                 checked, exp.status, exp.sector, exp.length, exp.sweep_up,
                                 exp.pending, got.status, got.sector, got.length,
                                 got.sweep_up, got.pending));
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_cmd;
   logic [SEC_W-1:0]    req_sector;
   logic [LEN_W-1:0]    req_length;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [SEC_W-1:0]    rsp_out_sector;
   logic [LEN_W-1:0]    rsp_out_length;
   logic                rsp_sweep_up;
   logic [CNT_W-1:0]    rsp_pending;

   elevator_scoreboard  sb;
   int                  cycle_count = 0;
   int                  items_sent = 0;
   int                  hold_offs_done = 0;
   bit                  hold_off_req = 1'b0;

   look_disk_request_scheduler_top #(
      .QUEUE_DEPTH(QDEPTH),
      .SECTOR_BITS(SEC_W),
      .LENGTH_BITS(LEN_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_sector(req_sector),
      .req_length(req_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_out_sector(rsp_out_sector),
      .rsp_out_length(rsp_out_length),
      .rsp_sweep_up(rsp_sweep_up),
      .rsp_pending(rsp_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Offers one transaction from the next falling edge and returns once it is taken.
   task automatic send_item(logic cmd, logic [SEC_W-1:0] sector, logic [LEN_W-1:0] length);
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sector <= sector;
      req_length <= length;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, sector, length);
      items_sent++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   function automatic logic [SEC_W-1:0] choose_sector(logic [SEC_W-1:0] head);
      int r;
      r = $urandom_range(0, 9);
      if (r <= 3) return SEC_W'({$urandom, $urandom});
      if (r <= 6) return SEC_W'($urandom_range(0, 63));
      if (r <= 8) return head + SEC_W'($urandom_range(0, 8)) - SEC_W'(4);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return SEC_MAX;
         2: return SEC_MAX - SEC_W'(1);
         default: return SEC_W'(1);
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] choose_length();
      int r;
      r = $urandom_range(0, 9);
      if (r == 8) return '0;
      if (r == 9) return LEN_MAX;
      if (r >= 6) return LEN_W'($urandom_range(0, 15));
      return LEN_W'($urandom_range(0, 65535));
   endfunction

   // Result channel: stalls follow a mode that changes every so often.
   initial begin
      int mode, span, period;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 200);
         period = $urandom_range(2, 6);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            if (hold_off_req) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES - 1) @(negedge clock);
               hold_off_req = 1'b0;
               hold_offs_done++;
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 1) == 1);
                  2: rsp_ready <= (k % period) != 0;
                  default: rsp_ready <= ($urandom_range(0, 7) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(sched_result_type'{status_type'(rsp_status), rsp_out_sector,
                                               rsp_out_length, rsp_sweep_up, rsp_pending});
      end
   end

   initial begin
      int burst_left, add_bias, seg_left;
      logic cmd;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_ADD;
      req_sector = '0;
      req_length = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty store, extremes, equal sectors, reversals, a lone
      // entry, the head wrapping past the top sector, and alternating bit patterns.
      send_item(CMD_DISPATCH, SEC_MAX, LEN_MAX);
      send_item(CMD_ADD, '0, '0);
      send_item(CMD_ADD, SEC_MAX, LEN_MAX);
      send_item(CMD_ADD, SEC_W'(100), LEN_W'(1));
      send_item(CMD_ADD, SEC_W'(100), LEN_W'(2));
      send_item(CMD_ADD, SEC_W'(100), LEN_W'(3));
      repeat (4) send_item(CMD_DISPATCH, '0, '0);
      send_item(CMD_ADD, SEC_W'(50), LEN_W'(7));
      send_item(CMD_ADD, SEC_W'(100), LEN_W'(9));
      repeat (4) send_item(CMD_DISPATCH, SEC_MAX, '0);
      send_item(CMD_ADD, 48'h5555_5555_5555, 16'hAAAA);
      send_item(CMD_ADD, 48'hAAAA_AAAA_AAAA, 16'h5555);
      repeat (3) send_item(CMD_DISPATCH, 48'hAAAA_AAAA_AAAA, 16'h5555);

      burst_left = 0;
      seg_left = 0;
      add_bias = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            // Add-heavy stretches fill the store to refusal, light ones drain it.
            case ($urandom_range(0, 2))
               0: add_bias = 85;
               1: add_bias = 50;
               default: add_bias = 15;
            endcase
            seg_left = $urandom_range(50, 150);
         end
         seg_left--;
         if (n == 600) hold_off_req = 1'b1;
         if (burst_left == 0) begin
            if (!hold_off_req && $urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         cmd = ($urandom_range(0, 99) < add_bias) ? CMD_ADD : CMD_DISPATCH;
         send_item(cmd, choose_sector(sb.head), choose_length());
      end
      idle_cycles(1);

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.awaited.size() != 0)
         sb.flag_error($sformatf("%0d results never arrived", sb.awaited.size()));
      $display("%0d transactions, %0d results checked, %0d errors, %0d long hold-offs",
               items_sent, sb.checked, sb.errors, hold_offs_done);
      $display("served %0d, refused full %0d, empty %0d, reversals %0d, wraps %0d, peak %0d",
               sb.n_served, sb.n_full, sb.n_empty, sb.n_reversals, sb.n_wraps,
               sb.peak_depth);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
